/* hdl/lce_pkg.sv */
// ----------------------------------------------------------------------------
// lce_pkg: shared types and constants of the leader clustering engine
// Holds the distance mode codes, the register indexes, the sequencer states
// and the payload widths.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CwW     = 32;
  localparam int unsigned ThrW    = 18;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned NumCoordFields = 4;

  typedef enum logic [1:0] {
    MODE_L1   = 2'd0,
    MODE_L2   = 2'd1,
    MODE_LINF = 2'd2,
    MODE_LINF_ALT = 2'd3
  } dist_mode_e;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_MODE      = 1'b1
  } reg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_ACC,
    ST_SCAN_CMP,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_DIV,
    ST_UPD_WR,
    ST_NEW_WR,
    ST_RESULT
  } seq_state_e;

  // Start and status of the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

/* hdl/lce_divider.sv */
// ----------------------------------------------------------------------------
// lce_divider: signed restoring divider
// Divides a signed numerator by an unsigned denominator one quotient bit per
// cycle and truncates toward zero.
// ----------------------------------------------------------------------------
module lce_divider
  import lce_pkg::*;
#(
  parameter int unsigned NumW = 50,
  parameter int unsigned DenW = 33
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic        [DenW-1:0] den_i,
  output div_ctrl_t              stat_o,
  output logic signed [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] mag_q, mag_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], mag_q[NumW-1]};
    if (start_i) begin
      neg_d  = num_i[NumW-1];
      mag_d  = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        mag_d = {mag_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        mag_d = {mag_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign quot_o = neg_q ? -$signed(mag_q) : $signed(mag_q);
  assign stat_o = '{start: start_i, busy: busy_q, done: done_q};

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");

endmodule

/* hdl/leader_clustering_engine.sv */
// ----------------------------------------------------------------------------
// leader_clustering_engine: sequential leader clustering of weighted points
// Scans the stored clusters in order, joins the point to the first one
// within the threshold and updates its centroid as a weighted mean, or
// opens a new cluster.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | words
//  in      | input     | in_valid/in_stall  | coord_0..3, point_weight
//  out     | output    | out_valid/out_stall| cluster_index, opened_new, table_full
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
//
// Scanning one cluster is a centroid memory read and one shared accumulate per
// coordinate, then the compare. A join works through each coordinate in turn:
// the read, both products, the start and the steps of the serial divider,
// its finish and the write; with a zero total weight a coordinate skips the
// divider. Opening a cluster writes one coordinate at a time. Reset empties
// the table at once through the cluster count; the stores are not cleared.
// The result word sits in an output register; the next word may be accepted
// and worked on while a stalled result holds, but the sequencer then waits
// in its result state until the register is free.
module leader_clustering_engine
  import lce_pkg::*;
#(
  parameter int unsigned DIMS = 4,
  parameter int unsigned MAX_CLUSTERS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] coord_0_i,
  input  logic signed [15:0] coord_1_i,
  input  logic signed [15:0] coord_2_i,
  input  logic signed [15:0] coord_3_i,
  input  logic        [15:0] point_weight_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         cluster_index_o,
  output logic               opened_new_o,
  output logic               table_full_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index_i,
  input  logic [17:0]        cfg_data_i
);

  localparam int unsigned ClW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int unsigned AddrW = $clog2(MAX_CLUSTERS * DIMS);
  localparam int unsigned AccW  = 40;   // sum of up to 8 squares of 17-bit magnitudes
  localparam int unsigned NumW  = 50;   // c*W + x*w with 32-bit W
  localparam int unsigned DenW  = 33;
  localparam int unsigned SqW   = 2 * CoordW + 2;
  localparam int unsigned CProdW = CoordW + CwW + 1;
  localparam int unsigned PProdW = CoordW + WeightW + 1;

  // Configuration registers.
  logic [ThrW-1:0] thr_q;
  dist_mode_e      mode_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      mode_q <= MODE_L2;
    end else if (cfg_valid) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_THRESHOLD: thr_q  <= cfg_data_i;
        REG_MODE:      mode_q <= dist_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Stores: centroids in a memory, weights in a memory.
  logic signed [CoordW-1:0] cent_mem [MAX_CLUSTERS*DIMS];
  logic [CwW-1:0]           wt_mem   [MAX_CLUSTERS];
  logic signed [CoordW-1:0] cent_rd_q;
  logic [CwW-1:0]           wt_rd_q;
  logic [AddrW-1:0]         cent_addr;
  logic                     cent_we;
  logic signed [CoordW-1:0] cent_wdata;
  logic                     wt_we;
  logic [CwW-1:0]           wt_wdata;

  // Sequencer registers.
  seq_state_e               state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [ClW-1:0]           cl_q, cl_d;
  logic [DW-1:0]            k_q, k_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic signed [CoordW-1:0] pt_q [DIMS];
  logic [WeightW-1:0]       w_q;
  logic [DenW-1:0]          tot_q, tot_d;
  logic signed [NumW-1:0]   num_q, num_d;
  logic [IdxOutW-1:0]       idx_q, idx_d;
  logic                     new_q, new_d, full_q, full_d;
  logic                     ov_q, ov_d;
  logic                     div_start;
  div_ctrl_t                div_stat;
  logic signed [NumW-1:0]   quot;

  logic signed [CoordW:0]   diff;
  logic [CoordW:0]          mag;
  logic [SqW-1:0]           sq;
  logic [AccW-1:0]          thr_sq;
  logic signed [CProdW-1:0] cent_prod;
  logic signed [PProdW-1:0] pt_prod;
  logic                     last_k, last_cl;

  logic signed [CoordW-1:0] coord_in [DIMS];
  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      coord_in[i] = '0;
    end
    coord_in[0] = coord_0_i;
    if (DIMS > 1) coord_in[1 % DIMS] = coord_1_i;
    if (DIMS > 2) coord_in[2 % DIMS] = coord_2_i;
    if (DIMS > 3) coord_in[3 % DIMS] = coord_3_i;
  end

  assign last_k  = (k_q == DW'(DIMS - 1));
  assign last_cl = (CntW'(cl_q) + CntW'(1)) >= count_q;
  assign cent_addr = AddrW'(cl_q * DIMS + k_q);

  // Shared arithmetic: one difference, its magnitude and its square.
  assign diff = {pt_q[k_q][CoordW-1], pt_q[k_q]} - {cent_rd_q[CoordW-1], cent_rd_q};
  assign mag  = diff[CoordW] ? (CoordW+1)'(-diff) : (CoordW+1)'(diff);
  assign sq   = SqW'(mag) * SqW'(mag);
  assign thr_sq = AccW'(thr_q) * AccW'(thr_q);

  // Products of the weighted mean, each at its full width.
  assign cent_prod = CProdW'($signed(cent_rd_q)) * CProdW'($signed({1'b0, wt_rd_q}));
  assign pt_prod   = PProdW'($signed(pt_q[k_q])) * PProdW'($signed({1'b0, w_q}));

  always_ff @(posedge clk_i) begin
    if (cent_we) cent_mem[cent_addr] <= cent_wdata;
    cent_rd_q <= cent_mem[cent_addr];
    if (wt_we) wt_mem[cl_q] <= wt_wdata;
    wt_rd_q <= wt_mem[cl_q];
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    cl_d    = cl_q;
    k_d     = k_q;
    acc_d   = acc_q;
    tot_d   = tot_q;
    num_d   = num_q;
    idx_d   = idx_q;
    new_d   = new_q;
    full_d  = full_q;
    ov_d    = ov_q;
    cent_we = 1'b0;
    cent_wdata = quot[CoordW-1:0];
    wt_we   = 1'b0;
    wt_wdata = (tot_q[DenW-1]) ? '1 : tot_q[CwW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid) begin
          cl_d  = '0;
          k_d   = '0;
          acc_d = '0;
          if (count_q == '0) state_d = ST_NEW_WR;
          else state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_ACC;
      ST_SCAN_ACC: begin
        unique case (mode_q)
          MODE_L1: acc_d = acc_q + AccW'(mag);
          MODE_L2: acc_d = acc_q + AccW'(sq);
          default: acc_d = (AccW'(mag) > acc_q) ? AccW'(mag) : acc_q;
        endcase
        if (last_k) state_d = ST_SCAN_CMP;
        else begin
          k_d = k_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_CMP: begin
        k_d = '0;
        if ((mode_q == MODE_L2) ? (acc_q <= thr_sq) : (acc_q <= AccW'(thr_q))) begin
          state_d = ST_UPD_RD;
        end else if (last_cl) begin
          if (count_q < CntW'(MAX_CLUSTERS)) begin
            cl_d = ClW'(count_q);
            state_d = ST_NEW_WR;
          end else begin
            idx_d = '0; new_d = 1'b0; full_d = 1'b1;
            state_d = ST_RESULT;
          end
        end else begin
          cl_d = cl_q + 1'b1;
          acc_d = '0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_UPD_RD: state_d = ST_UPD_MUL;
      ST_UPD_MUL: begin
        // Both products and the total weight; unless the total is zero, the divide
        // starts next cycle from the registered numerator and total.
        tot_d = {1'b0, wt_rd_q} + DenW'(w_q);
        num_d = NumW'(cent_prod) + NumW'(pt_prod);
        if (tot_d == '0) state_d = ST_UPD_WR;
        else state_d = ST_UPD_DIV;
      end
      ST_UPD_DIV: begin
        if (div_stat.done) begin
          cent_we = 1'b1;
          state_d = ST_UPD_WR;
        end else if (!div_stat.busy) begin
          div_start = 1'b1;
        end
      end
      ST_UPD_WR: begin
        if (last_k) begin
          wt_we = 1'b1;
          idx_d = IdxOutW'(cl_q); new_d = 1'b0; full_d = 1'b0;
          state_d = ST_RESULT;
        end else begin
          k_d = k_q + 1'b1;
          state_d = ST_UPD_RD;
        end
      end
      ST_NEW_WR: begin
        cent_we = 1'b1;
        cent_wdata = pt_q[k_q];
        if (last_k) begin
          wt_we = 1'b1;
          wt_wdata = CwW'(w_q);
          count_d = count_q + 1'b1;
          idx_d = IdxOutW'(cl_q); new_d = 1'b1; full_d = 1'b0;
          state_d = ST_RESULT;
        end else k_d = k_q + 1'b1;
      end
      ST_RESULT: begin
        if (!ov_q || !out_stall) begin
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (ov_q && !out_stall && state_q != ST_RESULT) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q  <= cl_d;
    k_q   <= k_d;
    acc_q <= acc_d;
    tot_q <= tot_d;
    num_q <= num_d;
    idx_q <= idx_d;
    new_q <= new_d;
    full_q <= full_d;
    if (state_q == ST_IDLE && in_valid) begin
      for (int i = 0; i < DIMS; i++) pt_q[i] <= coord_in[i];
      w_q <= point_weight_i;
    end
  end

  // Output register, loaded when the sequencer hands over a result.
  logic [5:0] oidx_q;
  logic       onew_q, ofull_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESULT && (!ov_q || !out_stall)) begin
      oidx_q  <= idx_q;
      onew_q  <= new_q;
      ofull_q <= full_q;
    end
  end

  assign in_stall        = (state_q != ST_IDLE);
  assign out_valid       = ov_q;
  assign cluster_index_o = oidx_q;
  assign opened_new_o    = onew_q;
  assign table_full_o    = ofull_q;

  lce_divider #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (tot_q),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_CLUSTERS)) else $error("cluster count overflow");
  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(opened_new_o && table_full_o)) else $error("bad result flags");
  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEW_WR && last_k) |=> count_q == $past(count_q) + 1'b1)
    else $error("new cluster not counted");

endmodule

/* bench/leader_clustering_checker.sv */
// ----------------------------------------------------------------------------
// leader_clustering_checker: assignment predictor and result comparator
// Watches the point, result and register channels of the clustering engine,
// keeps its own cluster table, predicts the assignment of every accepted
// point and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module leader_clustering_checker
  import lce_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] coord_0_i,
  input  logic signed [15:0] coord_1_i,
  input  logic signed [15:0] coord_2_i,
  input  logic signed [15:0] coord_3_i,
  input  logic        [15:0] point_weight_i,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [5:0]         cluster_index_i,
  input  logic               opened_new_i,
  input  logic               table_full_i,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index_i,
  input  logic [17:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 joined_o,
  output int                 opened_o,
  output int                 dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Dims = 4;

  typedef struct packed {
    logic [5:0] index;
    logic       opened;
    logic       full;
  } assignment_t;

  assignment_t        expected_assignments[$];
  logic signed [15:0] centroid[MAX_CLUSTERS][Dims];
  logic [31:0]        weight_sum[MAX_CLUSTERS];
  int unsigned        clusters_used;
  logic [17:0]        threshold;
  dist_mode_e         mode;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Scans the table in order, joins the first cluster in range or opens one, or reports a full table.
  function automatic assignment_t place_point(input logic signed [15:0] p0, p1, p2, p3,
                                              input logic [15:0] w);
    logic signed [15:0] pt[Dims];
    longint             diff, num, total, old_w, pw;
    longint unsigned    distance, mag, limit;
    assignment_t        res;
    pt[0] = p0;
    pt[1] = p1;
    pt[2] = p2;
    pt[3] = p3;
    limit = (mode == MODE_L2) ? longint'(threshold) * longint'(threshold)
                              : longint'(threshold);
    for (int j = 0; j < clusters_used; j++) begin
      distance = 0;
      for (int k = 0; k < Dims; k++) begin
        diff = longint'(pt[k]) - longint'(centroid[j][k]);
        mag = (diff < 0) ? -diff : diff;
        if (mode == MODE_L1) distance += mag;
        else if (mode == MODE_L2) distance += mag * mag;
        else if (mag > distance) distance = mag;
      end
      if (distance <= limit) begin
        old_w = {32'b0, weight_sum[j]};
        pw = {48'b0, w};
        total = old_w + pw;
        if (total != 0) begin
          for (int k = 0; k < Dims; k++) begin
            num = longint'(centroid[j][k]) * old_w + longint'(pt[k]) * pw;
            centroid[j][k] = 16'(num / total);
          end
        end
        weight_sum[j] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        res = '{index: j[5:0], opened: 1'b0, full: 1'b0};
        joined_o++;
        return res;
      end
    end
    if (clusters_used < MAX_CLUSTERS) begin
      for (int k = 0; k < Dims; k++) centroid[clusters_used][k] = pt[k];
      weight_sum[clusters_used] = 32'(w);
      res = '{index: clusters_used[5:0], opened: 1'b1, full: 1'b0};
      clusters_used++;
      opened_o++;
      return res;
    end
    dropped_o++;
    return '{index: 6'd0, opened: 1'b0, full: 1'b1};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    assignment_t want;
    if (!rst_ni) begin
      expected_assignments.delete();
      clusters_used = 0;
      threshold = '0;
      mode = MODE_L2;
      fail_count_o = 0;
      pending_o = 0;
      joined_o = 0;
      opened_o = 0;
      dropped_o = 0;
    end else begin
      // Results leave before new points are predicted: a result never
      // belongs to a point accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_assignments.size() == 0) begin
          report_mismatch("unexpected result word", cluster_index_i, -1);
        end else begin
          want = expected_assignments.pop_front();
          if (cluster_index_i !== want.index)
            report_mismatch("cluster_index", cluster_index_i, want.index);
          if (opened_new_i !== want.opened)
            report_mismatch("opened_new", opened_new_i, want.opened);
          if (table_full_i !== want.full)
            report_mismatch("table_full", table_full_i, want.full);
        end
      end
      if (in_valid && !in_stall) begin
        expected_assignments.push_back(place_point(coord_0_i, coord_1_i, coord_2_i,
                                                   coord_3_i, point_weight_i));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == REG_THRESHOLD) threshold = cfg_data_i;
        else mode = dist_mode_e'(cfg_data_i[1:0]);
      end
      pending_o = expected_assignments.size();
    end
  end

endmodule

/* bench/leader_clustering_engine_tb.sv */
// ----------------------------------------------------------------------------
// leader_clustering_engine_tb: stimulus and verdict for the clustering engine
// Drives directed edge points and then clustered random points through every
// distance mode and several thresholds, with random idling on both sides,
// and leaves the checking to the checker instance.
// ----------------------------------------------------------------------------
module leader_clustering_engine_tb;
  import lce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] coord_0_i, coord_1_i, coord_2_i, coord_3_i;
  logic        [15:0] point_weight_i;
  logic               out_valid;
  logic               out_stall;
  logic [5:0]         cluster_index_o;
  logic               opened_new_o;
  logic               table_full_o;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index_i;
  logic [17:0]        cfg_data_i;

  int  fail_count, pending, joined, opened, dropped;
  int  idle_cycles;
  int  hold_off_cycles;
  bit  no_idling;
  bit  start_hold_off;

  leader_clustering_engine DUT (
    .clk_i, .rst_ni,
    .in_valid, .in_stall,
    .coord_0_i, .coord_1_i, .coord_2_i, .coord_3_i, .point_weight_i,
    .out_valid, .out_stall,
    .cluster_index_o, .opened_new_o, .table_full_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  leader_clustering_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid, .in_stall,
    .coord_0_i, .coord_1_i, .coord_2_i, .coord_3_i, .point_weight_i,
    .out_valid, .out_stall,
    .cluster_index_i(cluster_index_o), .opened_new_i(opened_new_o),
    .table_full_i(table_full_o),
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .joined_o(joined), .opened_o(opened), .dropped_o(dropped)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The result side stalls at random. A requested hold-off keeps the stall
  // up for a long stretch so that the output register and then the point
  // channel back up while the sender keeps offering words.
  initial begin
    out_stall = 1'b1;
    hold_off_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (start_hold_off && hold_off_cycles == 0) hold_off_cycles = 400;
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idling && ($urandom_range(99) < 33);
      end
    end
  end

  // Any accepted word on any channel counts as progress.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no word moved for %0d cycles", WatchdogLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic write_register(input reg_index_e index, input logic [17:0] value);
    @(negedge clk_i);
    cfg_valid   <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Offers one point; valid may first drop at random.
  task automatic send_point(input logic [15:0] c0, c1, c2, c3, input logic [15:0] w);
    if (!no_idling && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid       <= 1'b1;
    coord_0_i      <= c0;
    coord_1_i      <= c1;
    coord_2_i      <= c2;
    coord_3_i      <= c3;
    point_weight_i <= w;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Lowers valid and waits until every predicted result has come back, so
  // that registers may be written safely.
  task automatic drain;
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_weight;
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  // Most points land near one of four random centers with an offset of up
  // to spread per coordinate; the rest are noise over the full range.
  task automatic clustered_phase(input logic [17:0] thr, input dist_mode_e m,
                                 input int count, input int spread);
    logic [15:0] center[4][4];
    logic [15:0] pt[4];
    int          c;
    write_register(REG_THRESHOLD, thr);
    write_register(REG_MODE, 18'(m));
    foreach (center[i, k]) center[i][k] = 16'($urandom);
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(99) < 70)
          pt[k] = center[c][k] + 16'($urandom_range(2 * spread) - spread);
        else pt[k] = 16'($urandom);
      end
      send_point(pt[0], pt[1], pt[2], pt[3], pick_weight());
    end
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    coord_0_i      = '0;
    coord_1_i      = '0;
    coord_2_i      = '0;
    coord_3_i      = '0;
    point_weight_i = '0;
    cfg_valid      = 1'b0;
    cfg_index_i    = REG_THRESHOLD;
    cfg_data_i     = '0;
    no_idling      = 1'b0;
    start_hold_off = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Exact matches only. A zero-weight point opens a cluster, a second one
    // joins it with a zero total weight, and the coordinate extremes open
    // clusters of their own, which repeated points then join.
    write_register(REG_THRESHOLD, 18'd0);
    write_register(REG_MODE, 18'(MODE_L2));
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd1);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd2);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1);
    drain();

    // Boundary distances around the origin cluster for each measure.
    write_register(REG_THRESHOLD, 18'd300);
    write_register(REG_MODE, 18'(MODE_L1));
    send_point(16'd100, 16'd100, 16'd50, 16'd49, 16'd7);
    send_point(16'd100, 16'd100, 16'd50, 16'd51, 16'd3);
    drain();
    write_register(REG_MODE, 18'(MODE_LINF));
    send_point(16'd300, -16'sd300, 16'd0, 16'd0, 16'd5);
    send_point(16'd301, 16'd0, 16'd0, 16'd0, 16'd5);
    drain();
    write_register(REG_MODE, 18'(MODE_LINF_ALT));
    send_point(-16'sd300, 16'd300, 16'd300, 16'd0, 16'd9);
    send_point(16'd0, 16'd0, -16'sd301, 16'd0, 16'd9);
    drain();
    write_register(REG_MODE, 18'(MODE_L2));
    send_point(16'd300, 16'd0, 16'd0, 16'd0, 16'd4);
    send_point(16'd212, 16'd212, 16'd0, 16'd0, 16'd4);
    send_point(16'd213, 16'd212, 16'd0, 16'd0, 16'd4);
    drain();

    // Random clustered traffic across the measures. The Chebyshev phase runs
    // without any idling; the squared phase has one long result hold-off.
    clustered_phase(18'd512, MODE_L1, 180, 200);
    no_idling = 1'b1;
    clustered_phase(18'd400, MODE_LINF, 180, 400);
    no_idling = 1'b0;
    clustered_phase(18'd256, MODE_LINF_ALT, 150, 300);
    fork
      clustered_phase(18'd300, MODE_L2, 150, 150);
      begin
        repeat (200) @(posedge clk_i);
        start_hold_off = 1'b1;
        @(posedge clk_i);
        start_hold_off = 1'b0;
      end
    join
    // Threshold zero with wide points fills the table and then drops points.
    clustered_phase(18'd0, MODE_L2, 100, 32767);
    // The largest threshold under L1 covers every possible distance.
    clustered_phase(18'h3FFFF, MODE_L1, 100, 32767);

    $display("Covered %0d joins, %0d new clusters and %0d dropped points", joined, opened,
             dropped);
    $display("over all four distance mode codes and thresholds from 0 to the maximum.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
